// ===== sv/occupancy_stillness_alert_fsm_unit_defines.svh =====
// Assertion macros for the occupancy stillness alert unit.
`ifndef OCCUPANCY_STILLNESS_ALERT_FSM_UNIT_DEFINES_SVH
`define OCCUPANCY_STILLNESS_ALERT_FSM_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define OSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define OSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/osa_pkg.sv =====
// Shared types, codes and helpers for the occupancy stillness alert unit.
package osa_pkg;

  localparam int unsigned READING_W = 7;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [READING_W-1:0] READING_MAX = 7'd100;

  typedef logic [READING_W-1:0] reading_t;
  typedef logic [TIME_W-1:0]    time_t;

  typedef enum logic [1:0] {
    ST_IDLE      = 2'd0,
    ST_COUNTDOWN = 2'd1,
    ST_DURATION  = 2'd2,
    ST_STILLNESS = 2'd3
  } osa_state_t;

  typedef enum logic [1:0] {
    ALERT_NONE      = 2'd0,
    ALERT_DURATION  = 2'd1,
    ALERT_STILLNESS = 2'd2
  } osa_alert_t;

  localparam logic [CFG_IDX_W-1:0] CFG_FAST_THR       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_THR       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTDOWN_LIM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DURATION_LIM   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STILLNESS_LIM  = 3'd4;

  localparam reading_t RST_FAST_THR      = 7'd10;
  localparam reading_t RST_SLOW_THR      = 7'd10;
  localparam time_t    RST_COUNTDOWN_LIM = 32'd15000;
  localparam time_t    RST_DURATION_LIM  = 32'd1200000;
  localparam time_t    RST_STILLNESS_LIM = 32'd120000;

  typedef struct packed {
    reading_t fast_thr;
    reading_t slow_thr;
    time_t    countdown_lim;
    time_t    duration_lim;
    time_t    stillness_lim;
  } osa_cfg_t;

  typedef struct packed {
    time_t    now_ms;
    logic     door_open;
    logic     door_closed;
    reading_t fast;
    reading_t slow;
  } osa_poll_t;

  typedef struct packed {
    osa_state_t state;
    logic       changed;
    osa_alert_t alert;
    time_t      elapsed;
  } osa_result_t;

  function automatic reading_t sat_reading(input reading_t v);
    return (v > READING_MAX) ? READING_MAX : v;
  endfunction

endpackage

// ===== sv/occupancy_stillness_alert_fsm_unit.sv =====
// Top level of the occupancy stillness alert unit: poll register, state machine, result register.
//
//  channel | signals                                              | beat
//  --------+------------------------------------------------------+---------------------
//  in      | in_valid/in_ready, now_ms, door_*, fast_level,       | one poll
//          | slow_level                                           |
//  out     | out_valid/out_ready, occupancy_state, state_changed, | one result per poll
//          | alert_kind, elapsed_ms                               |
//  cfg     | cfg_we, cfg_index, cfg_wdata                         | one register write
//
// One poll per cycle sustained while out_ready holds; a taken poll is held in the poll register and then
// in the result register before it appears as an output beat.
// The state machine commits when the poll register hands its beat to the result register.
// An output stall holds the result register; the poll register keeps taking beats until
// it is full too.
// rst clears state, entry time, valid flags and restores register defaults.
module occupancy_stillness_alert_fsm_unit
  import osa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TIME_W-1:0]     now_ms,
  input  logic                  door_open,
  input  logic                  door_closed,
  input  logic [READING_W-1:0]  fast_level,
  input  logic [READING_W-1:0]  slow_level,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            occupancy_state,
  output logic                  state_changed,
  output logic [1:0]            alert_kind,
  output logic [TIME_W-1:0]     elapsed_ms,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  osa_cfg_t    cfg;
  osa_poll_t   poll;
  logic        poll_valid;
  osa_result_t fsm_result;
  osa_result_t res;
  logic        res_free;
  logic        advance;

  assign res_free = !out_valid || out_ready;
  assign advance  = poll_valid && res_free;
  assign in_ready = !poll_valid || res_free;

  osa_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  osa_fsm u_fsm (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .commit (advance),
    .poll   (poll),
    .result (fsm_result)
  );

  // poll register
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_valid <= 1'b0;
    end else if (in_ready) begin
      poll_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      poll.now_ms      <= now_ms;
      poll.door_open   <= door_open;
      poll.door_closed <= door_closed;
      poll.fast        <= fast_level;
      poll.slow        <= slow_level;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_free) begin
      out_valid <= poll_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= fsm_result;
    end
  end

  assign occupancy_state = res.state;
  assign state_changed   = res.changed;
  assign alert_kind      = res.alert;
  assign elapsed_ms      = res.elapsed;

`include "occupancy_stillness_alert_fsm_unit_defines.svh"

  `OSA_ASSERT_NOW(a_alert_ends_idle, out_valid && alert_kind != ALERT_NONE,
    occupancy_state == ST_IDLE && state_changed, "alert without a move to idle")
  `OSA_ASSERT_NOW(a_ready_when_out_empty, !out_valid, in_ready,
    "input stalled with empty result register")
  `OSA_ASSERT_NEXT(a_advance_fills_out, advance, out_valid,
    "committed poll produced no result")
  `OSA_ASSERT_NOW(a_alert_code_valid, out_valid, alert_kind != 2'd3,
    "undefined alert code")

endmodule

// ===== sv/osa_cfg.sv =====
// Configuration register bank for the occupancy stillness alert unit.
module osa_cfg
  import osa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  we,
  input  logic [CFG_IDX_W-1:0]  index,
  input  logic [CFG_DATA_W-1:0] wdata,
  output osa_cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fast_thr      <= RST_FAST_THR;
      cfg.slow_thr      <= RST_SLOW_THR;
      cfg.countdown_lim <= RST_COUNTDOWN_LIM;
      cfg.duration_lim  <= RST_DURATION_LIM;
      cfg.stillness_lim <= RST_STILLNESS_LIM;
    end else if (we) begin
      unique case (index)
        CFG_FAST_THR:      cfg.fast_thr      <= wdata[READING_W-1:0];
        CFG_SLOW_THR:      cfg.slow_thr      <= wdata[READING_W-1:0];
        CFG_COUNTDOWN_LIM: cfg.countdown_lim <= wdata[TIME_W-1:0];
        CFG_DURATION_LIM:  cfg.duration_lim  <= wdata[TIME_W-1:0];
        CFG_STILLNESS_LIM: cfg.stillness_lim <= wdata[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sv/osa_fsm.sv =====
// Occupancy state machine: state and entry time registers, next-state and result logic.
module osa_fsm
  import osa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  osa_cfg_t    cfg,
  input  logic        commit,
  input  osa_poll_t   poll,
  output osa_result_t result
);

  osa_state_t state, state_next;
  time_t      start_time, start_time_next;
  osa_alert_t alert;
  time_t      elapsed;
  reading_t   fast, slow;

  assign fast    = sat_reading(poll.fast);
  assign slow    = sat_reading(poll.slow);
  assign elapsed = (state == ST_IDLE) ? '0 : poll.now_ms - start_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      start_time <= '0;
    end else if (commit) begin
      state      <= state_next;
      start_time <= start_time_next;
    end
  end

  // next state
  always_comb begin
    state_next      = state;
    start_time_next = start_time;
    alert           = ALERT_NONE;
    unique case (state)
      ST_IDLE: begin
        if (fast > cfg.fast_thr && poll.door_closed) begin
          state_next      = ST_COUNTDOWN;
          start_time_next = poll.now_ms;
        end
      end
      ST_COUNTDOWN: begin
        if (fast != '0 && fast < cfg.fast_thr) begin
          state_next = ST_IDLE;
        end else if (poll.door_open) begin
          state_next = ST_IDLE;
        end else if (elapsed >= cfg.countdown_lim) begin
          state_next      = ST_DURATION;
          start_time_next = poll.now_ms;
        end
      end
      ST_DURATION: begin
        if (fast != '0 && slow < cfg.slow_thr) begin
          state_next      = ST_STILLNESS;
          start_time_next = poll.now_ms;
        end else if (poll.door_open) begin
          state_next = ST_IDLE;
        end else if (elapsed >= cfg.duration_lim) begin
          state_next = ST_IDLE;
          alert      = ALERT_DURATION;
        end
      end
      ST_STILLNESS: begin
        if (slow > cfg.slow_thr) begin
          state_next      = ST_DURATION;
          start_time_next = poll.now_ms;
        end else if (poll.door_open) begin
          state_next = ST_IDLE;
        end else if (elapsed >= cfg.stillness_lim) begin
          state_next = ST_IDLE;
          alert      = ALERT_STILLNESS;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // result
  always_comb begin
    result.state   = state_next;
    result.changed = (state_next != state);
    result.alert   = alert;
    result.elapsed = elapsed;
  end

endmodule
